[hdl/maf_pkg.sv]
// ----------------------------------------------------------------------------
// maf_pkg
// Shared constants for the moving average filter: defaults, field widths
// and register map.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int AVG_W  = 24;
  localparam int FRAC_W = 8;
  localparam int WLEN_W = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd4;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;

endpackage

[hdl/maf_ram.sv]
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/moving_average_filter.sv]
// ----------------------------------------------------------------------------
// moving_average_filter
// Simple moving average of signed samples, result in signed Q8, truncated
// toward zero. Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Flow: an accepted item goes through S_READ, S_UPDATE, the bit-serial divider
//   (S_DIV, QW = SAMPLE_BITS + clog2(MAX_WINDOW) + 8 bits, 30 at defaults)
//   and S_DONE; S_DONE waits until the result register is free. One item in
//   flight, taken only in S_IDLE; result register frees the input.
// Reset: asynchronous, active low; window_length = 4, sum, fill count and
//   write pointer cleared. Sample RAM is not cleared.
module moving_average_filter
  import maf_pkg::AVG_W, maf_pkg::ADDR_W, maf_pkg::DATA_W,
         maf_pkg::MAX_WINDOW_DEF, maf_pkg::SAMPLE_BITS_DEF;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic signed [AVG_W-1:0]       average_q8_o,
  output logic                          window_full_o
);

  import maf_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int QW     = SUM_W + FRAC_W;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int EW     = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int RES_W  = (QW + 1 > AVG_W) ? QW + 1 : AVG_W;
  localparam int ITER_W = $clog2(QW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [WLEN_W-1:0]        wlen_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]         fill_q;
  logic [PTR_W-1:0]         wp_q;
  logic [PTR_W-1:0]         ptr_q;
  logic [SAMPLE_BITS-1:0]   smp_q;
  logic                     neg_q;
  logic                     full_q;
  logic [QW-1:0]            dq_q;
  logic [CNT_W-1:0]         rem_q;
  logic [ITER_W-1:0]        iter_q;
  logic                     out_valid_q;
  logic [AVG_W-1:0]         avg_q;
  logic                     win_full_q;

  logic                     cfg_wr;
  logic [EW-1:0]            wlen_ext;
  logic [EW-1:0]            max_ext;
  logic [EW-1:0]            n_ext;
  logic [CNT_W-1:0]         win_n;
  logic [PTR_W-1:0]         ptr_eff;
  logic [CNT_W-1:0]         ptr_inc;
  logic [PTR_W-1:0]         wp_d;
  logic                     full_pre;
  logic [CNT_W-1:0]         fill_d;
  logic [SAMPLE_BITS-1:0]   old_smp;
  logic signed [SUM_W-1:0]  old_ext;
  logic signed [SUM_W-1:0]  smp_ext;
  logic signed [SUM_W-1:0]  sum_d;
  logic [SUM_W-1:0]         abs_sum;
  logic [CNT_W:0]           rem_sh;
  logic                     q_bit;
  logic [CNT_W:0]           rem_sub;
  logic [CNT_W-1:0]         rem_d;
  logic [RES_W-1:0]         q_ext;
  logic [RES_W-1:0]         res;
  logic                     accept;
  logic                     out_load;

  assign pready = 1'b1;
  assign prdata = DATA_W'(wlen_q);
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_WINDOW_LENGTH);

  assign sample_ready_o = (state_q == S_IDLE);
  assign accept         = sample_valid_i & sample_ready_o;
  assign result_valid_o = out_valid_q;
  assign average_q8_o   = avg_q;
  assign window_full_o  = win_full_q;
  assign out_load       = ~out_valid_q | result_ready_i;

  // effective window: zero reads as one, clamp at MAX_WINDOW
  always_comb begin
    wlen_ext = EW'(wlen_q);
    max_ext  = EW'(MAX_WINDOW);
    if (wlen_q == '0) begin
      n_ext = EW'(1);
    end else if (wlen_ext > max_ext) begin
      n_ext = max_ext;
    end else begin
      n_ext = wlen_ext;
    end
    win_n = n_ext[CNT_W-1:0];
  end

  assign ptr_eff = (CNT_W'(wp_q) >= win_n) ? '0 : wp_q;
  assign ptr_inc = CNT_W'(ptr_q) + CNT_W'(1);
  assign wp_d    = (ptr_inc >= win_n) ? '0 : ptr_inc[PTR_W-1:0];

  assign full_pre = (fill_q >= win_n);
  assign fill_d   = full_pre ? win_n : fill_q + CNT_W'(1);
  assign old_ext  = SUM_W'($signed(old_smp));
  assign smp_ext  = SUM_W'($signed(smp_q));
  assign sum_d    = sum_q - (full_pre ? old_ext : '0) + smp_ext;
  assign abs_sum  = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);

  // one restoring step per cycle
  assign rem_sh  = {rem_q, dq_q[QW-1]};
  assign q_bit   = (rem_sh >= {1'b0, fill_q});
  assign rem_sub = rem_sh - {1'b0, fill_q};
  assign rem_d   = q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];

  assign q_ext = RES_W'(dq_q);
  assign res   = neg_q ? RES_W'(-q_ext) : q_ext;

  maf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == S_UPDATE),
    .waddr_i(ptr_q),
    .wdata_i(smp_q),
    .raddr_i(ptr_q),
    .rdata_o(old_smp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= WLEN_RST;
      sum_q       <= '0;
      fill_q      <= '0;
      wp_q        <= '0;
      ptr_q       <= '0;
      smp_q       <= '0;
      neg_q       <= 1'b0;
      full_q      <= 1'b0;
      dq_q        <= '0;
      rem_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      win_full_q  <= 1'b0;
    end else begin
      if (out_valid_q && result_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        wlen_q <= pwdata[WLEN_W-1:0];
        sum_q  <= '0;
        fill_q <= '0;
        wp_q   <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ptr_q   <= ptr_eff;
            smp_q   <= sample_i;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          sum_q   <= sum_d;
          fill_q  <= fill_d;
          wp_q    <= wp_d;
          full_q  <= full_pre | (fill_d == win_n);
          neg_q   <= sum_d[SUM_W-1];
          dq_q    <= {abs_sum, FRAC_W'(0)};
          rem_q   <= '0;
          iter_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          dq_q   <= {dq_q[QW-2:0], q_bit};
          rem_q  <= rem_d;
          iter_q <= iter_q + ITER_W'(1);
          if (iter_q == ITER_W'(QW - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            avg_q       <= res[AVG_W-1:0];
            win_full_q  <= full_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (out_valid_q && result_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/maf_chk.sv]
// ----------------------------------------------------------------------------
// maf_chk
// Port-level checks for the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module maf_chk
  import maf_pkg::AVG_W, maf_pkg::ADDR_W, maf_pkg::DATA_W;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [ADDR_W-1:0]      paddr,
  input logic [DATA_W-1:0]      pwdata,
  input logic [DATA_W-1:0]      prdata,
  input logic                   pready,
  input logic                   sample_valid_i,
  input logic                   sample_ready_o,
  input logic                   result_valid_o,
  input logic                   result_ready_i,
  input logic [AVG_W-1:0]       average_q8_o,
  input logic                   window_full_o
);

  import maf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o)
    else $error("result dropped before accept");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      $stable(average_q8_o) && $stable(window_full_o))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> !sample_ready_o ##1 !sample_ready_o)
    else $error("item taken while previous item in progress");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH) |=>
      prdata[WLEN_W-1:0] == $past(pwdata[WLEN_W-1:0]))
    else $error("window_length readback mismatch");

endmodule

bind moving_average_filter maf_chk u_maf_chk (.*);
